// File: design/aicd_pkg.sv
// ----------------------------------------------------------------------------
// A64 instruction class decoder package
// Field widths, class and subclass codes, and the result bundle.
// ----------------------------------------------------------------------------
package aicd_pkg;

    localparam int INSTR_W = 32;
    localparam int TOP_W   = 3;
    localparam int SUB_W   = 4;

    // top class codes
    localparam logic [TOP_W-1:0] TOP_UNALLOC  = 3'd0;
    localparam logic [TOP_W-1:0] TOP_DATA_IMM = 3'd1;
    localparam logic [TOP_W-1:0] TOP_BRANCH   = 3'd2;
    localparam logic [TOP_W-1:0] TOP_LDST     = 3'd3;
    localparam logic [TOP_W-1:0] TOP_DATA_REG = 3'd4;
    localparam logic [TOP_W-1:0] TOP_SIMD_FP  = 3'd5;

    localparam logic [SUB_W-1:0] SUB_NONE     = 4'd0;

    // data-processing immediate subclasses
    localparam logic [SUB_W-1:0] SUB_IMM_PCREL   = 4'd1;
    localparam logic [SUB_W-1:0] SUB_IMM_ADDSUB  = 4'd2;
    localparam logic [SUB_W-1:0] SUB_IMM_LOGICAL = 4'd3;
    localparam logic [SUB_W-1:0] SUB_IMM_MOVWIDE = 4'd4;
    localparam logic [SUB_W-1:0] SUB_IMM_BITFLD  = 4'd5;
    localparam logic [SUB_W-1:0] SUB_IMM_EXTRACT = 4'd6;

    // branch / system subclasses
    localparam logic [SUB_W-1:0] SUB_BR_COND     = 4'd1;
    localparam logic [SUB_W-1:0] SUB_BR_EXCEPT   = 4'd2;
    localparam logic [SUB_W-1:0] SUB_BR_SYSTEM   = 4'd3;
    localparam logic [SUB_W-1:0] SUB_BR_UNCD_REG = 4'd4;
    localparam logic [SUB_W-1:0] SUB_BR_UNCD_IMM = 4'd5;
    localparam logic [SUB_W-1:0] SUB_BR_CMP      = 4'd6;
    localparam logic [SUB_W-1:0] SUB_BR_TEST     = 4'd7;

    // data-processing register subclasses
    localparam logic [SUB_W-1:0] SUB_REG_LOGICAL = 4'd1;
    localparam logic [SUB_W-1:0] SUB_REG_ADDSUB  = 4'd2;
    localparam logic [SUB_W-1:0] SUB_REG_ADDEXT  = 4'd3;
    localparam logic [SUB_W-1:0] SUB_REG_CARRY   = 4'd4;
    localparam logic [SUB_W-1:0] SUB_REG_CCMPIMM = 4'd5;
    localparam logic [SUB_W-1:0] SUB_REG_CCMPREG = 4'd6;
    localparam logic [SUB_W-1:0] SUB_REG_CSEL    = 4'd7;
    localparam logic [SUB_W-1:0] SUB_REG_TWOSRC  = 4'd8;
    localparam logic [SUB_W-1:0] SUB_REG_ONESRC  = 4'd9;
    localparam logic [SUB_W-1:0] SUB_REG_THREE   = 4'd10;

    typedef struct packed {
        logic [TOP_W-1:0] top_class;
        logic [SUB_W-1:0] sub_class;
    } t_class_res;

endpackage

// File: design/aicd_if.sv
// ----------------------------------------------------------------------------
// A64 instruction class decoder channels
// Valid/ready channels for instruction words and class results.
// ----------------------------------------------------------------------------
interface aicd_instr_if;
    logic                         valid;
    logic                         ready;
    logic [aicd_pkg::INSTR_W-1:0] instr_word;

    modport source (output valid, output instr_word, input ready);
    modport sink   (input valid, input instr_word, output ready);
endinterface

interface aicd_class_if;
    logic                       valid;
    logic                       ready;
    logic [aicd_pkg::TOP_W-1:0] top_class;
    logic [aicd_pkg::SUB_W-1:0] sub_class;

    modport source (output valid, output top_class, output sub_class, input ready);
    modport sink   (input valid, input top_class, input sub_class, output ready);
endinterface

// File: design/aicd_classify.sv
// ----------------------------------------------------------------------------
// A64 instruction classifier
// Masked pattern decode of the top class and its subclass.
// ----------------------------------------------------------------------------
module aicd_classify (
    input  logic [aicd_pkg::INSTR_W-1:0] i_instr_word,
    output aicd_pkg::t_class_res         o_res
);

    logic [3:0]                 w_op0;
    logic [2:0]                 w_imm_op;
    logic [2:0]                 w_br_a;
    logic [3:0]                 w_br_b;
    logic                       w_p;
    logic                       w_q;
    logic [3:0]                 w_r;
    logic                       w_s;
    logic [aicd_pkg::TOP_W-1:0] w_top;
    logic [aicd_pkg::SUB_W-1:0] w_imm_sub;
    logic [aicd_pkg::SUB_W-1:0] w_br_sub;
    logic [aicd_pkg::SUB_W-1:0] w_reg_sub;

    assign w_op0    = i_instr_word[28:25];
    assign w_imm_op = i_instr_word[25:23];
    assign w_br_a   = i_instr_word[31:29];
    assign w_br_b   = i_instr_word[25:22];
    assign w_p      = i_instr_word[30];
    assign w_q      = i_instr_word[28];
    assign w_r      = i_instr_word[24:21];
    assign w_s      = i_instr_word[11];

    always_comb begin
        unique casez (w_op0)
            4'b100?: w_top = aicd_pkg::TOP_DATA_IMM;
            4'b101?: w_top = aicd_pkg::TOP_BRANCH;
            4'b?1?0: w_top = aicd_pkg::TOP_LDST;
            4'b?101: w_top = aicd_pkg::TOP_DATA_REG;
            4'b?111: w_top = aicd_pkg::TOP_SIMD_FP;
            default: w_top = aicd_pkg::TOP_UNALLOC;
        endcase
    end

    always_comb begin
        unique casez (w_imm_op)
            3'b00?:  w_imm_sub = aicd_pkg::SUB_IMM_PCREL;
            3'b01?:  w_imm_sub = aicd_pkg::SUB_IMM_ADDSUB;
            3'b100:  w_imm_sub = aicd_pkg::SUB_IMM_LOGICAL;
            3'b101:  w_imm_sub = aicd_pkg::SUB_IMM_MOVWIDE;
            3'b110:  w_imm_sub = aicd_pkg::SUB_IMM_BITFLD;
            default: w_imm_sub = aicd_pkg::SUB_IMM_EXTRACT;
        endcase
    end

    always_comb begin
        unique casez ({w_br_a, w_br_b})
            7'b010_0???: w_br_sub = aicd_pkg::SUB_BR_COND;
            7'b110_00??: w_br_sub = aicd_pkg::SUB_BR_EXCEPT;
            7'b110_0100: w_br_sub = aicd_pkg::SUB_BR_SYSTEM;
            7'b110_1???: w_br_sub = aicd_pkg::SUB_BR_UNCD_REG;
            7'b?00_????: w_br_sub = aicd_pkg::SUB_BR_UNCD_IMM;
            7'b?01_0???: w_br_sub = aicd_pkg::SUB_BR_CMP;
            7'b?01_1???: w_br_sub = aicd_pkg::SUB_BR_TEST;
            default:     w_br_sub = aicd_pkg::SUB_NONE;
        endcase
    end

    always_comb begin
        unique casez ({w_q, w_r})
            5'b0_0???: w_reg_sub = aicd_pkg::SUB_REG_LOGICAL;
            5'b0_1??0: w_reg_sub = aicd_pkg::SUB_REG_ADDSUB;
            5'b0_1??1: w_reg_sub = aicd_pkg::SUB_REG_ADDEXT;
            5'b1_0000: w_reg_sub = aicd_pkg::SUB_REG_CARRY;
            5'b1_0010: w_reg_sub = w_s ? aicd_pkg::SUB_REG_CCMPIMM
                                       : aicd_pkg::SUB_REG_CCMPREG;
            5'b1_0100: w_reg_sub = aicd_pkg::SUB_REG_CSEL;
            5'b1_0110: w_reg_sub = w_p ? aicd_pkg::SUB_REG_ONESRC
                                       : aicd_pkg::SUB_REG_TWOSRC;
            5'b1_1???: w_reg_sub = aicd_pkg::SUB_REG_THREE;
            default:   w_reg_sub = aicd_pkg::SUB_NONE;
        endcase
    end

    always_comb begin
        o_res.top_class = w_top;
        case (w_top)
            aicd_pkg::TOP_DATA_IMM: o_res.sub_class = w_imm_sub;
            aicd_pkg::TOP_BRANCH:   o_res.sub_class = w_br_sub;
            aicd_pkg::TOP_DATA_REG: o_res.sub_class = w_reg_sub;
            default:                o_res.sub_class = aicd_pkg::SUB_NONE;
        endcase
    end

endmodule

// File: design/a64_instruction_class_decoder_core.sv
// ----------------------------------------------------------------------------
// A64 instruction class decoder core
// An accepted word is held in the input register and classified combinationally
// into the result register. Throughput: one instruction word per cycle unless
// o_out stalls, set by the two-register pipeline.
// Reset: synchronous active-low i_rst_n clears both stage valid bits; no
// clearing pass, input ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module a64_instruction_class_decoder_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    aicd_instr_if.sink   i_in,
    aicd_class_if.source o_out
);

    logic                         r_s1_valid;
    logic [aicd_pkg::INSTR_W-1:0] r_s1_word;
    logic                         r_out_valid;
    aicd_pkg::t_class_res         r_out_res;
    aicd_pkg::t_class_res         n_out_res;
    logic                         w_s1_move;
    logic                         w_in_xfer;

    assign w_s1_move = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_s1_valid || w_s1_move;
    assign w_in_xfer  = i_in.valid && i_in.ready;

    aicd_classify u_classify (
        .i_instr_word (r_s1_word),
        .o_res        (n_out_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_s1_valid <= i_in.valid;
            end
            if (w_s1_move) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_s1_word <= i_in.instr_word;
        end
        if (w_s1_move && r_s1_valid) begin
            r_out_res <= n_out_res;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.top_class = r_out_res.top_class;
    assign o_out.sub_class = r_out_res.sub_class;

    a_in_to_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> r_s1_valid)
        else $error("accepted word missing from input stage");

    a_top_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_res.top_class <= aicd_pkg::TOP_SIMD_FP))
        else $error("top class out of range");

    a_sub_class_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_res.sub_class != aicd_pkg::SUB_NONE) |->
        (r_out_res.top_class == aicd_pkg::TOP_DATA_IMM ||
         r_out_res.top_class == aicd_pkg::TOP_BRANCH ||
         r_out_res.top_class == aicd_pkg::TOP_DATA_REG))
        else $error("subclass on a class without subclasses");

    a_imm_has_sub: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_res.top_class == aicd_pkg::TOP_DATA_IMM) |->
        (r_out_res.sub_class != aicd_pkg::SUB_NONE))
        else $error("data immediate word without subclass");

endmodule
